// ===== src/rate_monotonic_tick_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_DEFINES_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rmts_pkg.sv =====
package rmts_pkg;

  localparam int TASK_MAX   = 6;
  localparam int NUM_W      = 3;
  localparam int MASK_W     = 6;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Register index of the active task count; indexes below it are task setups.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TASKS = 3'd6;

  // Per-task status handed from a task slot to the priority picker.
  typedef struct packed {
    logic             ready;
    logic             released;
    logic [CNT_W-1:0] period;
  } slot_stat_t;

  typedef struct packed {
    logic             found;
    logic [NUM_W-1:0] chosen;
  } pick_res_t;

endpackage

// ===== src/rmts_slot.sv =====
module rmts_slot (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic                       enabled,
  input  logic                       restart,
  input  logic [rmts_pkg::CNT_W-1:0] period,
  input  logic [rmts_pkg::CNT_W-1:0] exec_ticks,
  input  logic                       run,
  output rmts_pkg::slot_stat_t       stat
);

  logic [rmts_pkg::CNT_W-1:0] countdown_r, countdown_nxt;
  logic [rmts_pkg::CNT_W-1:0] work_r, work_nxt;
  logic                       active;
  logic                       release_now;
  logic [rmts_pkg::CNT_W-1:0] work_rel;

  assign active      = enabled && (period != '0);
  assign release_now = active && (restart || (countdown_r == '0));
  // Work seen by the picker already includes this tick's release.
  assign work_rel    = release_now ? exec_ticks : work_r;

  assign stat.ready    = active && (work_rel != '0);
  assign stat.released = release_now;
  assign stat.period   = period;

  always_comb begin
    countdown_nxt = countdown_r;
    work_nxt      = work_r;
    if (!active) begin
      countdown_nxt = '0;
      work_nxt      = '0;
    end else begin
      countdown_nxt = release_now ? (period - 1'b1) : (countdown_r - 1'b1);
      work_nxt      = run ? (work_rel - 1'b1) : work_rel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= '0;
      work_r      <= '0;
    end else if (advance) begin
      countdown_r <= countdown_nxt;
      work_r      <= work_nxt;
    end
  end

endmodule

// ===== src/rmts_pick.sv =====
module rmts_pick #(
  parameter int TASK_SLOTS = 6
) (
  input  rmts_pkg::slot_stat_t stat [TASK_SLOTS],
  output rmts_pkg::pick_res_t  res,
  output logic [TASK_SLOTS-1:0] run
);

  logic [rmts_pkg::CNT_W-1:0] best;

  // Strict less-than keeps the lower index on equal periods.
  always_comb begin
    res.found  = 1'b0;
    res.chosen = '0;
    best       = '0;
    for (int k = 0; k < TASK_SLOTS; k++) begin
      if (stat[k].ready && (!res.found || (stat[k].period < best))) begin
        res.found  = 1'b1;
        res.chosen = rmts_pkg::NUM_W'(k);
        best       = stat[k].period;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < TASK_SLOTS; k++) begin
      run[k] = res.found && (res.chosen == rmts_pkg::NUM_W'(k));
    end
  end

endmodule

// ===== src/rate_monotonic_tick_scheduler.sv =====
// Rate-monotonic tick scheduler.
// Every input transaction is one time tick; in_tdata bit 0 is the restart flag,
// which sets time to zero so every enabled task with a nonzero period is released on that tick.
// Every tick yields exactly one output transaction: idle, the number of the
// task that ran (zero when idle) and the mask of tasks released on the tick.
// Tasks are set up through the write port: registers 0..5 hold the period
// (bits 15..0) and the execution ticks (bits 31..16) of each task, register 6
// the number of active tasks. Write them only while no tick is in flight.
// A tick is registered on acceptance, evaluated against the per-task
// countdown and work counters once the output register is free or being
// read, and its result lands in the output register, which drives out_tvalid.
// One tick is accepted per cycle while the receiver keeps taking results; the
// single pass through the task slots and the six-way shortest-period compare sets that rate.
// When the receiver stalls, the result stays in the output register and one
// more tick waits in the input register; in_tready drops only then.
// Reset clears the setups, the active count and all counters, so every task
// is released on its first tick once enabled.
`include "rate_monotonic_tick_scheduler_defines.svh"

module rate_monotonic_tick_scheduler #(
  parameter int TASK_SLOTS = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rmts_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] restart
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rmts_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] idle, [3:1] task_number,
                                                      // [9:4] released_mask
  input  logic                            cfg_we,
  input  logic [rmts_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rmts_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = rmts_pkg::CNT_W;
  localparam logic [rmts_pkg::NUM_W-1:0] SLOT_COUNT = rmts_pkg::NUM_W'(TASK_SLOTS);

  logic [rmts_pkg::CFG_DATA_W-1:0] setup_r [TASK_SLOTS];
  logic [rmts_pkg::NUM_W-1:0]      active_r;

  logic                            s1_valid_r;
  logic                            s1_restart_r;
  logic                            advance;

  logic                            out_valid_r;
  logic [rmts_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [rmts_pkg::OUT_DATA_W-1:0] out_data_nxt;
  logic                            out_idle;
  logic [rmts_pkg::NUM_W-1:0]      out_task;

  rmts_pkg::slot_stat_t            stat [TASK_SLOTS];
  rmts_pkg::pick_res_t             pick;
  logic [TASK_SLOTS-1:0]           run;
  logic [rmts_pkg::MASK_W-1:0]     released_mask;

  // Configuration registers; setup writes beyond the slot count are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        setup_r[k] <= '0;
      end
      active_r <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == rmts_pkg::REG_ACTIVE_TASKS) begin
        active_r <= cfg_wdata[rmts_pkg::NUM_W-1:0];
      end else begin
        for (int k = 0; k < TASK_SLOTS; k++) begin
          if (cfg_idx == rmts_pkg::CFG_IDX_W'(k)) begin
            setup_r[k] <= cfg_wdata;
          end
        end
      end
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_restart_r <= in_tdata[0];
    end
  end

  genvar g;
  generate
    for (g = 0; g < TASK_SLOTS; g++) begin : g_slot
      // An active count above the slot count enables every slot.
      rmts_slot u_slot (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .enabled    (active_r > rmts_pkg::NUM_W'(g)),
        .restart    (s1_restart_r),
        .period     (setup_r[g][CW-1:0]),
        .exec_ticks (setup_r[g][2*CW-1:CW]),
        .run        (run[g]),
        .stat       (stat[g])
      );
    end
  endgenerate

  rmts_pick #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_pick (
    .stat (stat),
    .res  (pick),
    .run  (run)
  );

  always_comb begin
    released_mask = '0;
    for (int k = 0; k < TASK_SLOTS; k++) begin
      released_mask[k] = stat[k].released;
    end
  end

  assign out_data_nxt = {6'd0, released_mask, pick.chosen, !pick.found};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign out_idle = out_data_r[0];
  assign out_task = out_data_r[3:1];

  `RMTS_ASSERT_SAME(a_idle_task_zero, out_valid_r && out_idle, out_task == '0, "task on idle")
  `RMTS_ASSERT_SAME(a_task_range, out_valid_r && !out_idle, out_task < SLOT_COUNT, "bad task")
  `RMTS_ASSERT_NEXT(a_tick_held, s1_valid_r && !advance, s1_valid_r, "tick dropped")
  `RMTS_ASSERT_SAME(a_ready_when_empty, !out_valid_r, in_tready, "input stalled while empty")

endmodule

// ===== tb/rmts_checker.sv =====
`timescale 1ns / 1ps

module rmts_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rmts_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] restart
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rmts_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] idle, [3:1] task_number,
                                                      // [9:4] released_mask
  input  logic                            cfg_we,
  input  logic [rmts_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rmts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              ticks_pending,
  output int                              fail_count
);

  localparam int NW = rmts_pkg::NUM_W;
  localparam int MW = rmts_pkg::MASK_W;
  localparam int CW = rmts_pkg::CNT_W;
  localparam int DW = rmts_pkg::CFG_DATA_W;
  localparam int TM = rmts_pkg::TASK_MAX;

  typedef struct packed {
    logic          idle;
    logic [NW-1:0] task_number;
    logic [MW-1:0] released_mask;
  } tick_result_t;

  logic [DW-1:0] task_setup [TM];
  logic [2:0]    active_count;
  logic [CW-1:0] countdown [TM];
  logic [CW-1:0] work_left [TM];
  tick_result_t  expected_ticks [$];

  // Advances the scheduler state by one tick and returns what the tick yields.
  function automatic tick_result_t schedule_tick(input logic restart);
    int unsigned   enabled;
    logic [CW-1:0] period;
    logic [CW-1:0] best_period;
    logic          found;
    tick_result_t  res;
    enabled = (active_count > TM) ? TM : active_count;
    res = '0;
    found = 1'b0;
    best_period = '0;
    for (int k = 0; k < TM; k++) begin
      period = task_setup[k][CW-1:0];
      if (k >= enabled || period == '0) begin
        countdown[k] = '0;
        work_left[k] = '0;
      end else if (restart || countdown[k] == '0) begin
        // A release drops whatever work was left from the previous period.
        work_left[k] = task_setup[k][DW-1:CW];
        countdown[k] = period - 1'b1;
        res.released_mask[k] = 1'b1;
      end else begin
        countdown[k] = countdown[k] - 1'b1;
      end
    end
    for (int k = 0; k < TM; k++) begin
      period = task_setup[k][CW-1:0];
      if (k < enabled && period != '0 && work_left[k] != '0 &&
          (!found || period < best_period)) begin
        found = 1'b1;
        res.task_number = k[NW-1:0];
        best_period = period;
      end
    end
    if (found) work_left[res.task_number] = work_left[res.task_number] - 1'b1;
    res.idle = !found;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    tick_result_t got;
    tick_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < TM; k++) begin
        task_setup[k] = '0;
        countdown[k]  = '0;
        work_left[k]  = '0;
      end
      active_count = '0;
      expected_ticks.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.idle          = out_tdata[0];
        got.task_number   = out_tdata[NW:1];
        got.released_mask = out_tdata[NW+MW:NW+1];
        if (expected_ticks.size() == 0) begin
          flag_mismatch("result with no tick pending, tdata", 0, out_tdata);
        end else begin
          want = expected_ticks.pop_front();
          if (got.idle != want.idle)
            flag_mismatch("idle", want.idle, got.idle);
          if (got.task_number != want.task_number)
            flag_mismatch("task_number", want.task_number, got.task_number);
          if (got.released_mask != want.released_mask)
            flag_mismatch("released_mask", want.released_mask, got.released_mask);
        end
      end
      if (in_tvalid && in_tready)
        expected_ticks.push_back(schedule_tick(in_tdata[0]));
      if (cfg_we) begin
        if (cfg_idx < rmts_pkg::REG_ACTIVE_TASKS)
          task_setup[cfg_idx] = cfg_wdata;
        else if (cfg_idx == rmts_pkg::REG_ACTIVE_TASKS)
          active_count = cfg_wdata[2:0];
      end
    end
    ticks_pending = expected_ticks.size();
  end

endmodule

// ===== tb/rate_monotonic_tick_scheduler_tb.sv =====
`timescale 1ns / 1ps

module rate_monotonic_tick_scheduler_tb;

  localparam int IW = rmts_pkg::CFG_IDX_W;
  localparam int DW = rmts_pkg::CFG_DATA_W;
  localparam int CW = rmts_pkg::CNT_W;
  localparam int TM = rmts_pkg::TASK_MAX;

  localparam logic [IW-1:0] REG_UNUSED = 3'd7;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int STALL_LIMIT     = 2000;
  localparam int PHASES          = 14;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [rmts_pkg::IN_DATA_W-1:0]  in_tdata;   // [0] restart
  logic                            out_tvalid;
  logic                            out_tready;
  logic [rmts_pkg::OUT_DATA_W-1:0] out_tdata;  // [0] idle, [3:1] task_number,
                                               // [9:4] released_mask
  logic                            cfg_we;
  logic [IW-1:0]                   cfg_idx;
  logic [DW-1:0]                   cfg_wdata;

  int   ticks_pending;
  int   fail_count;
  logic calm;
  logic hold_req;
  logic hold_taken;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   stall_cycles;

  rate_monotonic_tick_scheduler #(
    .TASK_SLOTS(TM)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  rmts_checker schedule_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .ticks_pending (ticks_pending),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register index of the setup of task k.
  function automatic logic [IW-1:0] task_reg(input int k);
    return IW'(k);
  endfunction

  // All stimulus tasks start and end just after a falling edge.
  task automatic write_reg(input logic [IW-1:0] idx,
                           input logic [DW-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_tick(input logic restart);
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(rmts_pkg::IN_DATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (ticks_pending != 0) @(negedge clk);
  endtask

  function automatic logic [DW-1:0] rand_setup();
    logic [CW-1:0] period;
    logic [CW-1:0] exec_ticks;
    case ($urandom_range(0, 9))
      0:       period = '0;
      1:       period = '1;
      2:       period = CW'($urandom);
      default: period = CW'($urandom_range(1, 10));
    endcase
    case ($urandom_range(0, 9))
      0:       exec_ticks = '0;
      1:       exec_ticks = '1;
      2:       exec_ticks = CW'($urandom);
      default: exec_ticks = CW'($urandom_range(1, 4));
    endcase
    return {exec_ticks, period};
  endfunction

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    hold_taken = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        out_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_taken = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_tready = 1'b1;
      @(negedge clk);
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int n;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Nothing configured: every tick is idle.
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drained();

    // Ties on period, zero period, zero execution time, maximum fields, and an
    // active count above the number of slots.
    write_reg(task_reg(0), {16'd2, 16'd4});
    write_reg(task_reg(1), {16'd1, 16'd2});
    write_reg(task_reg(2), {16'd2, 16'd4});
    write_reg(task_reg(3), {16'd5, 16'd0});
    write_reg(task_reg(4), {16'd0, 16'd3});
    write_reg(task_reg(5), 32'hFFFF_FFFF);
    write_reg(rmts_pkg::REG_ACTIVE_TASKS, 32'd7);
    for (int i = 0; i < 10; i++) send_tick(i == 5);
    wait_drained();

    // Period changed while counting down; upper tasks drop out of use.
    write_reg(task_reg(1), {16'd1, 16'd5});
    write_reg(rmts_pkg::REG_ACTIVE_TASKS, 32'd3);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_tick(1'b0);
    wait_drained();

    for (int k = 0; k < TM; k++) write_reg(task_reg(k), {16'd1, 16'd1});
    write_reg(rmts_pkg::REG_ACTIVE_TASKS, 32'd6);
    for (int i = 0; i < 3; i++) send_tick(1'b0);
    wait_drained();
    write_reg(rmts_pkg::REG_ACTIVE_TASKS, 32'd0);
    send_tick(1'b0);
    send_tick(1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      calm         = (phase == PHASES - 1);
      tx_idle_pct  = calm ? 0 : 12 * $urandom_range(0, 3);
      rx_stall_pct = calm ? 0 : 12 * $urandom_range(0, 3);
      if (phase == 0) begin
        for (int k = 0; k < TM; k++) write_reg(task_reg(k), 32'hFFFF_FFFF);
        write_reg(rmts_pkg::REG_ACTIVE_TASKS, 32'd7);
      end else if (phase % 3 == 2) begin
        // Only a few setups change, so running countdowns carry over.
        repeat (2) write_reg(task_reg($urandom_range(0, TM - 1)), rand_setup());
      end else begin
        for (int k = 0; k < TM; k++) write_reg(task_reg(k), rand_setup());
        write_reg(rmts_pkg::REG_ACTIVE_TASKS, ($urandom_range(0, 5) != 0) ?
                  $urandom_range(3, 7) : $urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
      end
      if (phase == 2) hold_req = 1'b1;
      n = $urandom_range(100, 120);
      for (int i = 0; i < n; i++) begin
        if (phase == 5 && i == n / 2) wait_drained();
        send_tick($urandom_range(0, 15) == 0);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && ticks_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
